// ----- rtl/rgb_to_yuv420_converter_defines.svh -----
// Assertion macros used by the checker file of the converter.
`ifndef RGB_TO_YUV420_CONVERTER_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define R2Y_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define R2Y_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/r2y_pkg.sv -----
`timescale 1ns / 1ps

package r2y_pkg;

  localparam int MAX_DIM        = 4096;
  localparam int COEF_FRAC_BITS = 16;

  localparam int PIX_W     = 8;
  localparam int OFS_W     = 24;
  localparam int CFG_DIM_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CNT_W     = $clog2(MAX_DIM);

  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int ACC_W  = PROD_W + 2;

  localparam int MUL_A_W = DIM_W + 1;
  localparam int MUL_W   = MUL_A_W + CNT_W;
  localparam int SUM_W   = (MUL_W + 1 > OFS_W) ? MUL_W + 1 : OFS_W;

  localparam int PQ_DEPTH = 4;
  localparam int PQ_IDX_W = $clog2(PQ_DEPTH);
  localparam int PQ_CNT_W = $clog2(PQ_DEPTH + 1);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_IDX_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam int unsigned WIDTH_RST  = 640;
  localparam int unsigned HEIGHT_RST = 480;

  // Coefficients are given in units of 1e-5 and rounded half away from zero.
  localparam longint SCALE_DEN = 100000;
  localparam longint KY_R  =  ((longint'(29900) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint KY_G  =  ((longint'(58700) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint KY_B  =  ((longint'(11400) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint KCB_R = -((longint'(14713) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint KCB_G = -((longint'(28886) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint KCB_B =  ((longint'(43600) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint KCR_R =  ((longint'(61500) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint KCR_G = -((longint'(51499) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint KCR_B = -((longint'(10001) << COEF_FRAC_BITS) + SCALE_DEN / 2) / SCALE_DEN;
  localparam longint CHROMA_BIAS = longint'(128) << COEF_FRAC_BITS;

  typedef enum logic [1:0] {
    PLANE_Y  = 2'd0,
    PLANE_CB = 2'd1,
    PLANE_CR = 2'd2
  } plane_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LAYOUT = 2'd2
  } cfg_reg_e;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    coef_t kr;
    coef_t kg;
    coef_t kb;
  } coef_set_t;

  // One accepted pixel with everything the back end needs to expand it.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic [DIM_W-1:0] width;
    logic             nv12;
    logic             chroma;
  } pix_t;

  typedef struct packed {
    plane_e           plane;
    logic             last;
    prod_t            prod_r;
    prod_t            prod_g;
    prod_t            prod_b;
    logic [MUL_W-1:0] ofs_prod;
    logic [CNT_W:0]   ofs_add;
  } mac_t;

  typedef struct packed {
    plane_e           plane;
    logic [OFS_W-1:0] ofs;
    logic [PIX_W-1:0] value;
    logic             last;
  } res_t;

  function automatic coef_set_t coef_set(plane_e p);
    coef_set_t cs;
    unique case (p)
      PLANE_Y: begin
        cs.kr = coef_t'(KY_R);
        cs.kg = coef_t'(KY_G);
        cs.kb = coef_t'(KY_B);
      end
      PLANE_CB: begin
        cs.kr = coef_t'(KCB_R);
        cs.kg = coef_t'(KCB_G);
        cs.kb = coef_t'(KCB_B);
      end
      PLANE_CR: begin
        cs.kr = coef_t'(KCR_R);
        cs.kg = coef_t'(KCR_G);
        cs.kb = coef_t'(KCR_B);
      end
      default: begin
        cs = '0;
      end
    endcase
    return cs;
  endfunction

endpackage

// ----- rtl/r2y_pix_queue.sv -----
`timescale 1ns / 1ps

module r2y_pix_queue
  import r2y_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output pix_t data_o
);

  pix_t                mem_q [PQ_DEPTH];
  logic [PQ_IDX_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PQ_IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PQ_CNT_W-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == PQ_CNT_W'(PQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PQ_IDX_W'(PQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PQ_IDX_W'(PQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/r2y_res_queue.sv -----
`timescale 1ns / 1ps

module r2y_res_queue
  import r2y_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  res_t                data_i,
  input  logic                pop_i,
  output logic                empty_o,
  output res_t                data_o,
  output logic [RQ_CNT_W-1:0] count_o
);

  res_t                mem_q [RQ_DEPTH];
  logic [RQ_IDX_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RQ_IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RQ_CNT_W-1:0] count_q, count_d;
  logic                do_pop;

  // The writer reserves space ahead of time, so a push never meets a full queue.
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == RQ_IDX_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == RQ_IDX_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/r2y_front.sv -----
`timescale 1ns / 1ps

module r2y_front
  import r2y_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DIM_W-1:0] cfg_data_i,
  input  logic                 accept_i,
  input  logic [PIX_W-1:0]     red_i,
  input  logic [PIX_W-1:0]     green_i,
  input  logic [PIX_W-1:0]     blue_i,
  output pix_t                 pix_o
);

  logic [CFG_DIM_W-1:0] width_q, width_d;
  logic [CFG_DIM_W-1:0] height_q, height_d;
  logic                 nv12_q, nv12_d;
  logic [CNT_W-1:0]     col_q, col_d;
  logic [CNT_W-1:0]     row_q, row_d;
  logic [DIM_W-1:0]     dim_w, dim_h;
  logic [CNT_W:0]       col_inc, row_inc;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (int'(v) < 2) begin
      r = DIM_W'(2);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    nv12_d   = nv12_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_WIDTH:  width_d  = cfg_data_i;
        REG_HEIGHT: height_d = cfg_data_i;
        REG_LAYOUT: nv12_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign dim_w   = clamp_dim(width_q);
  assign dim_h   = clamp_dim(height_q);
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;

  // Advance the raster position; a stale counter past the edge wraps on its next step.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (int'(col_inc) >= int'(dim_w)) begin
        col_d = '0;
        row_d = (int'(row_inc) >= int'(dim_h)) ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_d = col_inc[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    pix_o.red    = red_i;
    pix_o.green  = green_i;
    pix_o.blue   = blue_i;
    pix_o.col    = col_q;
    pix_o.row    = row_q;
    pix_o.width  = dim_w;
    pix_o.nv12   = nv12_q;
    pix_o.chroma = !col_q[0] && !row_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DIM_W'(WIDTH_RST);
      height_q <= CFG_DIM_W'(HEIGHT_RST);
      nv12_q   <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      nv12_q   <= nv12_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

// ----- rtl/r2y_back.sv -----
`timescale 1ns / 1ps

module r2y_back
  import r2y_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pq_empty_i,
  input  pix_t                pq_data_i,
  output logic                pq_pop_o,
  input  logic [RQ_CNT_W-1:0] rq_count_i,
  output logic                rq_push_o,
  output res_t                rq_data_o
);

  plane_e               sel_q, sel_d;
  logic                 s1_v_q, s2_v_q;
  mac_t                 s1_q, s1_d;
  res_t                 s2_q, s2_d;
  logic                 issue, last_cur;
  logic [RQ_CNT_W:0]    pending;
  coef_set_t            cs;
  logic signed [PIX_W:0] r_s, g_s, b_s;
  logic [DIM_W:0]       wp1;
  logic [MUL_A_W-1:0]   mul_a;
  logic [CNT_W-1:0]     mul_b;
  acc_t                 acc, bias;
  logic [SUM_W-1:0]     ofs_sum;

  // Reserve a queue slot for every result still in the pipeline.
  assign pending = (RQ_CNT_W + 1)'(rq_count_i) + (RQ_CNT_W + 1)'(s1_v_q)
                 + (RQ_CNT_W + 1)'(s2_v_q);
  assign issue   = !pq_empty_i && (int'(pending) < RQ_DEPTH);

  // Sample sequencer: luma, then Cb and Cr for chroma-sited pixels.
  always_comb begin
    sel_d = sel_q;
    if (issue) begin
      unique case (sel_q)
        PLANE_Y:  sel_d = pq_data_i.chroma ? PLANE_CB : PLANE_Y;
        PLANE_CB: sel_d = PLANE_CR;
        PLANE_CR: sel_d = PLANE_Y;
        default:  sel_d = PLANE_Y;
      endcase
    end
  end

  always_comb begin
    unique case (sel_q)
      PLANE_Y:  last_cur = !pq_data_i.chroma;
      PLANE_CB: last_cur = 1'b0;
      PLANE_CR: last_cur = 1'b1;
      default:  last_cur = 1'b1;
    endcase
    pq_pop_o = issue && last_cur;
  end

  // Stage 1: products of the pixel and the offset multiply.
  always_comb begin
    cs    = coef_set(sel_q);
    r_s   = $signed({1'b0, pq_data_i.red});
    g_s   = $signed({1'b0, pq_data_i.green});
    b_s   = $signed({1'b0, pq_data_i.blue});
    wp1   = {1'b0, pq_data_i.width} + 1'b1;
    mul_a = MUL_A_W'(pq_data_i.width);
    mul_b = pq_data_i.row;
    s1_d.ofs_add = {1'b0, pq_data_i.col};
    if (sel_q != PLANE_Y) begin
      mul_b = pq_data_i.row >> 1;
      if (pq_data_i.nv12) begin
        mul_a = MUL_A_W'({wp1[DIM_W:1], 1'b0});
        s1_d.ofs_add = {1'b0, pq_data_i.col} + (CNT_W + 1)'(sel_q == PLANE_CR);
      end else begin
        mul_a = MUL_A_W'(wp1[DIM_W:1]);
        s1_d.ofs_add = {1'b0, pq_data_i.col >> 1};
      end
    end
    s1_d.plane    = sel_q;
    s1_d.last     = last_cur;
    s1_d.prod_r   = prod_t'(r_s) * prod_t'(cs.kr);
    s1_d.prod_g   = prod_t'(g_s) * prod_t'(cs.kg);
    s1_d.prod_b   = prod_t'(b_s) * prod_t'(cs.kb);
    s1_d.ofs_prod = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // Stage 2: sum, clamp to a byte, final offset.
  always_comb begin
    bias = (s1_q.plane == PLANE_Y) ? '0 : acc_t'(CHROMA_BIAS);
    acc  = acc_t'(s1_q.prod_r) + acc_t'(s1_q.prod_g) + acc_t'(s1_q.prod_b) + bias;
    ofs_sum = SUM_W'(s1_q.ofs_prod) + SUM_W'(s1_q.ofs_add);
    s2_d.plane = s1_q.plane;
    s2_d.last  = s1_q.last;
    s2_d.ofs   = ofs_sum[OFS_W-1:0];
    if (acc[ACC_W-1]) begin
      s2_d.value = '0;
    end else if (|acc[ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
      s2_d.value = '1;
    end else begin
      s2_d.value = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
    end
  end

  assign rq_push_o = s2_v_q;
  assign rq_data_o = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= PLANE_Y;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      sel_q  <= sel_d;
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

endmodule

// ----- rtl/rgb_to_yuv420_converter.sv -----
`timescale 1ns / 1ps

// RGB to YUV 4:2:0 stream converter with BT.601 weights in Q16. Push one RGB
// pixel per request in raster order; every pixel yields a luma sample, and a
// pixel at an even column of an even row also yields a Cb and then a Cr
// sample, with last_of_pixel_o set on the final sample of each pixel. Each
// sample carries its plane and its byte offset within that plane (I420 or
// NV12 addressing per the layout register). The back end produces one sample
// per clock while a pixel is queued and the result queue has room to reserve.
// Each sample passes through the pixel queue, stage 1, stage 2 and the result
// queue. Frame registers go through the cfg port (valid/ready, always ready)
// and must change only while the block is drained; dimensions outside
// 2..MAX_DIM are saturated.

module rgb_to_yuv420_converter
  import r2y_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel requests
  input  logic                 push,
  output logic                 full,
  input  logic [PIX_W-1:0]     red_i,
  input  logic [PIX_W-1:0]     green_i,
  input  logic [PIX_W-1:0]     blue_i,
  // sample results
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           plane_o,
  output logic [OFS_W-1:0]     byte_offset_o,
  output logic [PIX_W-1:0]     sample_value_o,
  output logic                 last_of_pixel_o,
  // register writes
  input  logic                 valid,
  output logic                 ready,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DIM_W-1:0] cfg_data_i
);

  pix_t                pix;
  pix_t                pq_data;
  logic                pq_empty, pq_pop;
  logic                accept;
  logic                rq_push;
  res_t                rq_wdata, rq_rdata;
  logic [RQ_CNT_W-1:0] rq_count;

  assign ready  = 1'b1;
  assign accept = push && !full;

  // Front: register file, raster counters, chroma siting.
  r2y_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (valid),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .pix_o       (pix)
  );

  // Decouple the front from the sample sequencer.
  r2y_pix_queue u_pix_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pix),
    .full_o  (full),
    .pop_i   (pq_pop),
    .empty_o (pq_empty),
    .data_o  (pq_data)
  );

  // Back: expand each pixel into samples and convert them.
  r2y_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pq_empty_i (pq_empty),
    .pq_data_i  (pq_data),
    .pq_pop_o   (pq_pop),
    .rq_count_i (rq_count),
    .rq_push_o  (rq_push),
    .rq_data_o  (rq_wdata)
  );

  // Hold finished samples until the consumer pops them.
  r2y_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_wdata),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (rq_rdata),
    .count_o (rq_count)
  );

  assign plane_o         = rq_rdata.plane;
  assign byte_offset_o   = rq_rdata.ofs;
  assign sample_value_o  = rq_rdata.value;
  assign last_of_pixel_o = rq_rdata.last;

endmodule

// ----- rtl/r2y_checker.sv -----
`timescale 1ns / 1ps

`include "rgb_to_yuv420_converter_defines.svh"

module r2y_checker
  import r2y_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input logic [1:0]           plane_o,
  input logic [OFS_W-1:0]     byte_offset_o,
  input logic [PIX_W-1:0]     sample_value_o,
  input logic                 last_of_pixel_o
);

  // A shown sample names a real plane.
  `R2Y_ASSERT_NOW(a_plane_legal, clk_i, rst_ni, !empty, (plane_o == PLANE_Y || plane_o == PLANE_CB || plane_o == PLANE_CR), "result plane is not Y, Cb or Cr")

  // A Cb sample is never marked last of its pixel, since Cr follows it.
  `R2Y_ASSERT_NOW(a_cb_not_last, clk_i, rst_ni, !empty && plane_o == PLANE_CB, !last_of_pixel_o, "Cb sample marked last of pixel")

  // Cr always closes its pixel.
  `R2Y_ASSERT_NOW(a_cr_last, clk_i, rst_ni, !empty && plane_o == PLANE_CR, last_of_pixel_o, "Cr sample not marked last of pixel")

  // A result not taken stays on the ports.
  `R2Y_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(plane_o) && $stable(byte_offset_o) && $stable(sample_value_o) && $stable(last_of_pixel_o), "waiting result changed before pop")

endmodule

bind rgb_to_yuv420_converter r2y_checker u_r2y_checker (.*);
